// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define PFDE_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define PFDE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PFDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pfde_pkg.sv =====
// ---------------------------------------------------------------------------
// pfde_pkg
// Types and constants shared by the draw engine controller and datapath.
// ---------------------------------------------------------------------------
package pfde_pkg;

    localparam int ACTION_W = 3;
    localparam int COORD_W  = 8;
    localparam int BYTE_W   = 8;

    localparam logic [BYTE_W-1:0] BYTE_ALL_ON  = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_ALL_OFF = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_TOP_BIT = 8'h01;

    // Drawing command codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_PIXEL  = 3'd0,
        ACT_COLUMN = 3'd1,
        ACT_ROW    = 3'd2,
        ACT_FILL   = 3'd3,
        ACT_BOX    = 3'd4,
        ACT_READ   = 3'd5
    } t_action;

    // Which line segment the pixel walker is loaded with.
    typedef enum logic [2:0] {
        LD_PIXEL  = 3'd0,
        LD_ROW    = 3'd1,
        LD_TOP    = 3'd2,
        LD_BOTTOM = 3'd3,
        LD_LEFT   = 3'd4,
        LD_RIGHT  = 3'd5
    } t_edge_sel;

    // Memory address source.
    typedef enum logic [1:0] {
        AS_FILL   = 2'd0,
        AS_COLUMN = 2'd1,
        AS_PIXEL  = 2'd2,
        AS_READ   = 2'd3
    } t_addr_sel;

    // Memory write data source.
    typedef enum logic [1:0] {
        WS_ZERO    = 2'd0,
        WS_PATTERN = 2'd1,
        WS_COLUMN  = 2'd2,
        WS_PIXEL   = 2'd3
    } t_wdata_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       load_edge;
        t_edge_sel  edge_sel;
        logic       step_cur;
        logic       mem_rd;
        logic       mem_wr;
        t_addr_sel  addr_sel;
        t_wdata_sel wdata_sel;
        logic       fill_step;
        logic       band_step;
        logic       load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       at_end;
        logic       pix_on_screen;
        logic       col_on_screen;
        logic       fill_last;
        logic       band_last;
        logic [3:0] box_empty;
    } t_status;

endpackage

// ===== hdl/page_framebuffer_draw_engine.sv =====
// Commands are taken one at a time: a new command is accepted only in the idle state,
// once the previous one has finished and no read result is waiting to be loaded.
// Reset: synchronous, active low; a clearing pass then zeroes the store, and no
// command is taken until it ends.
// ---------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Monochrome page framebuffer with pixel, row, column, fill, box and read
// commands over a streaming request interface.
// ---------------------------------------------------------------------------
module page_framebuffer_draw_engine #(
    parameter int BLOCKS_ACROSS = 5,
    parameter int BANDS_DOWN    = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], x_first[10:3], y_first[18:11], x_second[26:19],
    // y_second[34:27], pixel_value[42:35], zero [47:43]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // column_byte[7:0]
    output logic [7:0]  m_axis_tdata
);

    pfde_pkg::t_cmd    cmd;
    pfde_pkg::t_status status;

    // Controller: handshakes and command sequencing.
    pfde_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_action  (s_axis_tdata[2:0]),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    // Datapath: frame memory and drawing arithmetic.
    pfde_datapath #(
        .BLOCKS_ACROSS (BLOCKS_ACROSS),
        .BANDS_DOWN    (BANDS_DOWN)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_x_first     (s_axis_tdata[10:3]),
        .i_y_first     (s_axis_tdata[18:11]),
        .i_x_second    (s_axis_tdata[26:19]),
        .i_y_second    (s_axis_tdata[34:27]),
        .i_pixel_value (s_axis_tdata[42:35]),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_column_byte (m_axis_tdata)
    );

endmodule

// ===== hdl/pfde_ctrl.sv =====
// ---------------------------------------------------------------------------
// pfde_ctrl
// Command sequencer: handshakes, clearing pass, fill, column, pixel walk and
// box edge stepping, and the result valid flag.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pfde_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_valid,
    output logic                               o_s_ready,
    input  logic [pfde_pkg::ACTION_W-1:0]      i_action,
    output logic                               o_m_valid,
    input  logic                               i_m_ready,
    input  pfde_pkg::t_status                  i_status,
    output pfde_pkg::t_cmd                     o_cmd
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_FILL   = 8'b0000_0100,
        S_COLUMN = 8'b0000_1000,
        S_EDGE   = 8'b0001_0000,
        S_PIX_RD = 8'b0010_0000,
        S_PIX_WR = 8'b0100_0000,
        S_READ   = 8'b1000_0000
    } t_state;

    // A result waiting for the output register; set by S_READ, cleared once loaded.
    logic   r_result_pend, n_result_pend;
    t_state r_state, n_state;
    logic [1:0] r_edge, n_edge;
    logic   r_box, n_box;
    logic   r_row, n_row;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   walk_done;
    logic   read_taken;

    assign o_s_ready  = (r_state == S_IDLE) && !r_result_pend;
    assign o_m_valid  = r_out_valid;
    assign accept     = i_s_valid && o_s_ready;
    assign read_taken = accept && (i_action == pfde_pkg::ACT_READ);

    // Next state and command decode.
    always_comb begin
        n_state       = r_state;
        n_edge        = r_edge;
        n_box         = r_box;
        n_row         = r_row;
        n_out_valid   = r_out_valid;
        n_result_pend = r_result_pend;
        walk_done     = 1'b0;

        o_cmd.capture   = 1'b0;
        o_cmd.load_edge = 1'b0;
        o_cmd.edge_sel  = pfde_pkg::LD_PIXEL;
        o_cmd.step_cur  = 1'b0;
        o_cmd.mem_rd    = 1'b0;
        o_cmd.mem_wr    = 1'b0;
        o_cmd.addr_sel  = pfde_pkg::AS_FILL;
        o_cmd.wdata_sel = pfde_pkg::WS_ZERO;
        o_cmd.fill_step = 1'b0;
        o_cmd.band_step = 1'b0;
        o_cmd.load_out  = 1'b0;

        if (r_out_valid && i_m_ready) begin
            n_out_valid = 1'b0;
        end

        // A fetched read byte moves to the output register once it is free.
        if (r_result_pend && (!r_out_valid || i_m_ready)) begin
            o_cmd.load_out = 1'b1;
            n_out_valid    = 1'b1;
            n_result_pend  = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                o_cmd.mem_wr    = 1'b1;
                o_cmd.addr_sel  = pfde_pkg::AS_FILL;
                o_cmd.wdata_sel = pfde_pkg::WS_ZERO;
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_box  = 1'b0;
                    n_row  = 1'b0;
                    n_edge = 2'd0;
                    case (pfde_pkg::t_action'(i_action))
                        pfde_pkg::ACT_PIXEL:  n_state = S_EDGE;
                        pfde_pkg::ACT_ROW: begin
                            n_row   = 1'b1;
                            n_state = S_EDGE;
                        end
                        pfde_pkg::ACT_BOX: begin
                            n_box   = 1'b1;
                            n_state = S_EDGE;
                        end
                        pfde_pkg::ACT_COLUMN: n_state = S_COLUMN;
                        pfde_pkg::ACT_FILL:   n_state = S_FILL;
                        pfde_pkg::ACT_READ:   n_state = S_READ;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_FILL: begin
                o_cmd.mem_wr    = 1'b1;
                o_cmd.addr_sel  = pfde_pkg::AS_FILL;
                o_cmd.wdata_sel = pfde_pkg::WS_PATTERN;
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_COLUMN: begin
                if (!i_status.col_on_screen) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.mem_wr    = 1'b1;
                    o_cmd.addr_sel  = pfde_pkg::AS_COLUMN;
                    o_cmd.wdata_sel = pfde_pkg::WS_COLUMN;
                    o_cmd.band_step = 1'b1;
                    if (i_status.band_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EDGE: begin
                if (r_box && i_status.box_empty[r_edge]) begin
                    if (r_edge == 2'd3) begin
                        n_state = S_IDLE;
                    end else begin
                        n_edge = r_edge + 2'd1;
                    end
                end else begin
                    o_cmd.load_edge = 1'b1;
                    if (r_box) begin
                        case (r_edge)
                            2'd0:    o_cmd.edge_sel = pfde_pkg::LD_TOP;
                            2'd1:    o_cmd.edge_sel = pfde_pkg::LD_BOTTOM;
                            2'd2:    o_cmd.edge_sel = pfde_pkg::LD_LEFT;
                            default: o_cmd.edge_sel = pfde_pkg::LD_RIGHT;
                        endcase
                    end else if (r_row) begin
                        o_cmd.edge_sel = pfde_pkg::LD_ROW;
                    end else begin
                        o_cmd.edge_sel = pfde_pkg::LD_PIXEL;
                    end
                    n_state = S_PIX_RD;
                end
            end
            S_PIX_RD: begin
                if (i_status.pix_on_screen) begin
                    o_cmd.mem_rd   = 1'b1;
                    o_cmd.addr_sel = pfde_pkg::AS_PIXEL;
                    n_state        = S_PIX_WR;
                end else begin
                    walk_done = 1'b1;
                end
            end
            S_PIX_WR: begin
                o_cmd.mem_wr    = 1'b1;
                o_cmd.addr_sel  = pfde_pkg::AS_PIXEL;
                o_cmd.wdata_sel = pfde_pkg::WS_PIXEL;
                walk_done       = 1'b1;
            end
            S_READ: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = pfde_pkg::AS_READ;
                n_result_pend  = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // Advance the walker after one pixel, move to the next box edge, or return to idle.
        if (walk_done) begin
            if (!i_status.at_end) begin
                o_cmd.step_cur = 1'b1;
                n_state        = S_PIX_RD;
            end else if (r_box && (r_edge != 2'd3)) begin
                n_edge  = r_edge + 2'd1;
                n_state = S_EDGE;
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_edge        <= 2'd0;
            r_box         <= 1'b0;
            r_row         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_result_pend <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_edge        <= n_edge;
            r_box         <= n_box;
            r_row         <= n_row;
            r_out_valid   <= n_out_valid;
            r_result_pend <= n_result_pend;
        end
    end

    // A read command is fetched in the cycle after it is taken.
    `PFDE_ASSERT_NEXT(a_read_issue, read_taken, r_state == S_READ, "read command not issued")
    // Every pixel write is preceded by the read of the same byte.
    `PFDE_ASSERT_IMPLY(a_rmw_order, r_state == S_PIX_WR, $past(o_cmd.mem_rd), "write without read")
    // The output register is only loaded once it is free.
    `PFDE_ASSERT_IMPLY(a_out_free, o_cmd.load_out, !r_out_valid || i_m_ready, "result overwritten")

endmodule

// ===== hdl/pfde_datapath.sv =====
// ---------------------------------------------------------------------------
// pfde_datapath
// Command field capture, fill and band counters, line walker, frame memory
// with a registered read port, pixel merge and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pfde_datapath #(
    parameter int BLOCKS_ACROSS = 5,
    parameter int BANDS_DOWN    = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [pfde_pkg::COORD_W-1:0]      i_x_first,
    input  logic [pfde_pkg::COORD_W-1:0]      i_y_first,
    input  logic [pfde_pkg::COORD_W-1:0]      i_x_second,
    input  logic [pfde_pkg::COORD_W-1:0]      i_y_second,
    input  logic [pfde_pkg::BYTE_W-1:0]       i_pixel_value,
    input  pfde_pkg::t_cmd                    i_cmd,
    output pfde_pkg::t_status                 o_status,
    output logic [pfde_pkg::BYTE_W-1:0]       o_column_byte
);

    localparam int COLS  = 16 * BLOCKS_ACROSS;
    localparam int ROWS  = 8 * BANDS_DOWN;
    localparam int BW    = $clog2(BANDS_DOWN);
    localparam int AW    = BW + pfde_pkg::COORD_W;
    localparam int DEPTH = BANDS_DOWN * 256;

    localparam logic [pfde_pkg::COORD_W-1:0] COL_LAST  = pfde_pkg::COORD_W'(COLS - 1);
    localparam logic [BW-1:0]                BAND_LAST = BW'(BANDS_DOWN - 1);

    logic [pfde_pkg::COORD_W-1:0] r_xa, r_ya, r_xb, r_yb;
    logic [pfde_pkg::BYTE_W-1:0]  r_val;
    logic [BW-1:0]                r_band, n_band;
    logic [pfde_pkg::COORD_W-1:0] r_col, n_col;
    logic [pfde_pkg::COORD_W-1:0] r_cur, r_end, r_fixed;
    logic                         r_horiz;
    logic                         r_on;
    logic [pfde_pkg::BYTE_W-1:0]  r_rdata;
    logic [pfde_pkg::BYTE_W-1:0]  r_out;
    logic [pfde_pkg::BYTE_W-1:0]  mem [DEPTH];

    logic [pfde_pkg::COORD_W-1:0] px, py;
    logic [pfde_pkg::BYTE_W-1:0]  bit_mask;
    logic [pfde_pkg::BYTE_W-1:0]  wdata;
    logic [AW-1:0]                addr;
    logic                         read_ok;
    logic                         pixel_wr;

    // Command fields are held for the whole command.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_xa  <= i_x_first;
            r_ya  <= i_y_first;
            r_xb  <= i_x_second;
            r_yb  <= i_y_second;
            r_val <= i_pixel_value;
        end
    end

    // Band and column counters for the fill and column walks.
    always_comb begin
        n_band = r_band;
        n_col  = r_col;
        if (i_cmd.capture) begin
            n_band = '0;
            n_col  = '0;
        end else if (i_cmd.fill_step) begin
            if (r_col == COL_LAST) begin
                n_col  = '0;
                n_band = (r_band == BAND_LAST) ? '0 : r_band + BW'(1);
            end else begin
                n_col = r_col + pfde_pkg::COORD_W'(1);
            end
        end else if (i_cmd.band_step) begin
            n_band = (r_band == BAND_LAST) ? '0 : r_band + BW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band <= '0;
            r_col  <= '0;
        end else begin
            r_band <= n_band;
            r_col  <= n_col;
        end
    end

    // Line walker: a moving coordinate from start to end on a fixed line.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_edge) begin
            case (i_cmd.edge_sel)
                pfde_pkg::LD_PIXEL: begin
                    r_cur <= r_xa; r_end <= r_xa; r_fixed <= r_ya;
                    r_horiz <= 1'b1; r_on <= (r_val != '0);
                end
                pfde_pkg::LD_ROW: begin
                    r_cur <= '0; r_end <= COL_LAST; r_fixed <= r_ya;
                    r_horiz <= 1'b1; r_on <= (r_val != '0);
                end
                pfde_pkg::LD_TOP: begin
                    r_cur <= r_xa; r_end <= r_xb; r_fixed <= r_ya;
                    r_horiz <= 1'b1; r_on <= 1'b1;
                end
                pfde_pkg::LD_BOTTOM: begin
                    r_cur <= r_xa; r_end <= r_xb; r_fixed <= r_yb;
                    r_horiz <= 1'b1; r_on <= 1'b1;
                end
                pfde_pkg::LD_LEFT: begin
                    r_cur <= r_ya; r_end <= r_yb; r_fixed <= r_xa;
                    r_horiz <= 1'b0; r_on <= 1'b1;
                end
                default: begin
                    r_cur <= r_ya; r_end <= r_yb; r_fixed <= r_xb;
                    r_horiz <= 1'b0; r_on <= 1'b1;
                end
            endcase
        end else if (i_cmd.step_cur) begin
            r_cur <= r_cur + pfde_pkg::COORD_W'(1);
        end
    end

    assign px = r_horiz ? r_cur : r_fixed;
    assign py = r_horiz ? r_fixed : r_cur;

    // Status back to the controller.
    assign read_ok                = (r_xa < COLS) && (r_ya[7:3] < BANDS_DOWN);
    assign o_status.at_end        = (r_cur == r_end);
    assign o_status.pix_on_screen = (px < COLS) && (py < ROWS);
    assign o_status.col_on_screen = (r_xa < COLS);
    assign o_status.fill_last     = (r_band == BAND_LAST) && (r_col == COL_LAST);
    assign o_status.band_last     = (r_band == BAND_LAST);
    assign o_status.box_empty     = {r_ya > r_yb, r_ya > r_yb, r_xa > r_xb, r_xa > r_xb};

    // Address: band in the upper bits, column in the lower eight.
    always_comb begin
        case (i_cmd.addr_sel)
            pfde_pkg::AS_FILL:   addr = {r_band, r_col};
            pfde_pkg::AS_COLUMN: addr = {r_band, r_xa};
            pfde_pkg::AS_PIXEL:  addr = {py[BW+2:3], px};
            default:             addr = {r_ya[BW+2:3], r_xa};
        endcase
    end

    // Write data, including the set or clear of one bit of the fetched byte.
    assign bit_mask = pfde_pkg::BYTE_TOP_BIT << py[2:0];

    always_comb begin
        case (i_cmd.wdata_sel)
            pfde_pkg::WS_ZERO:    wdata = pfde_pkg::BYTE_ALL_OFF;
            pfde_pkg::WS_PATTERN: wdata = r_val;
            pfde_pkg::WS_COLUMN:  wdata = (r_val != '0) ? pfde_pkg::BYTE_ALL_ON
                                                        : pfde_pkg::BYTE_ALL_OFF;
            default:              wdata = r_on ? (r_rdata | bit_mask) : (r_rdata & ~bit_mask);
        endcase
    end

    // Frame memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rdata <= mem[addr];
        end
    end

    // Result register; an off-screen read returns zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= read_ok ? r_rdata : pfde_pkg::BYTE_ALL_OFF;
        end
    end

    assign o_column_byte = r_out;

    // A pixel merge being written back.
    assign pixel_wr = i_cmd.mem_wr && (i_cmd.wdata_sel == pfde_pkg::WS_PIXEL);

    // The band counter never leaves the screen.
    `PFDE_ASSERT_ALWAYS(a_band_range, r_band <= BAND_LAST, "band counter out of range")
    // A pixel merge is only written back for an on-screen pixel.
    `PFDE_ASSERT_IMPLY(a_pixel_wr, pixel_wr, o_status.pix_on_screen, "off-screen pixel written")

endmodule
